[rtl/mat_pkg.sv]
`default_nettype none

package mat_pkg;

  // width of every word field on the item and result ports
  localparam int FIELD_W = 32;

  typedef logic [FIELD_W-1:0] field_t;

endpackage

`default_nettype wire

[rtl/mat_table_ram.sv]
`default_nettype none

module mat_table_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // single port: a write cycle gives no read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/mat_entry_gen.sv]
`default_nettype none

module mat_entry_gen #(
  parameter int CHUNK_BITS = 8
) (
  input  logic                  rho,
  input  logic                  carry,
  input  logic [CHUNK_BITS-1:0] ri,
  input  logic [CHUNK_BITS-1:0] val,
  output logic [CHUNK_BITS:0]   entry
);

  logic [CHUNK_BITS:0] sum;

  // real carry in is the table carry with the flip bit removed
  assign sum   = {1'b0, val} + {1'b0, ri} + (CHUNK_BITS+1)'(carry ^ rho);
  // boolean chunk masked by ri, carry out masked by rho
  assign entry = sum ^ {rho, ri};

endmodule

`default_nettype wire

[rtl/masked_a2b_table_conversion.sv]
// channel   direction  handshake          payload
// item      in         start & !busy      arith_share, mask_value, carry_flip, chunk_random
// result    out        done (one cycle)   bool_share
//
// an item first fills the whole table of 2*CHUNKS*2^CHUNK_BITS entries, one table entry
// written per cycle through the single memory port, then each chunk passes through a read
// state and a use state.
// busy is high from the cycle after start until done; the next item can start in the done cycle.
// rst is synchronous and returns the control to idle; table contents are kept.
// done cannot be held off: the receiver must take bool_share in that cycle.
`default_nettype none

module masked_a2b_table_conversion #(
  parameter int CHUNKS     = 4,
  parameter int CHUNK_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mat_pkg::field_t arith_share,
  input  mat_pkg::field_t mask_value,
  input  logic            carry_flip,
  input  mat_pkg::field_t chunk_random,
  output logic            done,
  output mat_pkg::field_t bool_share
);

  import mat_pkg::*;

  localparam int TOTAL = CHUNKS * CHUNK_BITS;
  localparam int DEPTH = 2 * CHUNKS * (2 ** CHUNK_BITS);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DW    = CHUNK_BITS + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_USE  = 2'd3;

  logic [1:0]                            state;
  logic [AW-1:0]                         cnt;
  logic [CW-1:0]                         idx;
  logic                                  beta;
  logic                                  rho;
  logic [TOTAL-1:0]                      acc;
  logic [TOTAL-1:0]                      msk;
  logic [TOTAL-1:0]                      live;
  logic [CHUNKS-1:0][CHUNK_BITS-1:0]     rnd;
  logic [CHUNKS-1:0][CHUNK_BITS-1:0]     res;
  logic [CHUNKS-1:0][CHUNK_BITS-1:0]     res_next;

  logic [TOTAL+FIELD_W-1:0] share_ext;
  logic [TOTAL+FIELD_W-1:0] mask_ext;
  logic [TOTAL+FIELD_W-1:0] rnd_ext;
  logic [TOTAL+FIELD_W-1:0] out_ext;
  logic [TOTAL-1:0]         rnd_in;
  logic [TOTAL-1:0]         res_flat;

  logic                  accept;
  logic [CW-1:0]         fill_chunk;
  logic [DW-1:0]         fill_entry;
  logic [CHUNK_BITS-1:0] ml;
  logic [TOTAL-1:0]      acc_sum;
  logic [AW-1:0]         look_addr;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DW-1:0]         ram_rdata;
  logic                  last_chunk;
  logic                  fill_last;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  // fit the 32-bit fields to the conversion word, either way round
  assign share_ext = {TOTAL'(0), arith_share};
  assign mask_ext  = {TOTAL'(0), mask_value};
  assign rnd_ext   = {TOTAL'(0), chunk_random};
  assign rnd_in    = rnd_ext[TOTAL-1:0];

  // table fill: counter is {chunk, carry, value}
  assign fill_chunk = CW'(cnt >> (CHUNK_BITS + 1));
  assign fill_last  = (cnt == AW'(DEPTH - 1));

  mat_entry_gen #(
    .CHUNK_BITS(CHUNK_BITS)
  ) u_entry_gen (
    .rho  (rho),
    .carry(cnt[CHUNK_BITS]),
    .ri   (rnd[fill_chunk]),
    .val  (cnt[CHUNK_BITS-1:0]),
    .entry(fill_entry)
  );

  // lookup walk; the add may carry into the higher chunks of acc
  assign ml         = msk[CHUNK_BITS-1:0];
  assign acc_sum    = (acc + TOTAL'(ml)) & live;
  assign look_addr  = (AW'(idx) << (CHUNK_BITS + 1)) | (AW'(beta) << CHUNK_BITS)
                    | AW'(acc_sum[CHUNK_BITS-1:0]);
  assign last_chunk = (idx == CW'(CHUNKS - 1));

  assign ram_we   = (state == S_FILL);
  assign ram_addr = ram_we ? cnt : look_addr;

  mat_table_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (DW)
  ) u_table_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(fill_entry),
    .rdata(ram_rdata)
  );

  always_comb begin
    res_next      = res;
    res_next[idx] = ram_rdata[CHUNK_BITS-1:0] ^ ml;
  end

  assign res_flat = res_next ^ rnd;
  assign out_ext  = {FIELD_W'(0), res_flat};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_last) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_USE;
        end
        S_USE: begin
          if (last_chunk) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt  <= '0;
      idx  <= '0;
      rho  <= carry_flip;
      beta <= carry_flip;
      rnd  <= rnd_in;
      acc  <= share_ext[TOTAL-1:0] - rnd_in;
      msk  <= mask_ext[TOTAL-1:0];
      live <= '1;
    end else begin
      case (state)
        S_FILL: begin
          cnt <= cnt + AW'(1);
        end
        S_READ: begin
          acc <= acc_sum;
        end
        S_USE: begin
          beta <= ram_rdata[CHUNK_BITS];
          res  <= res_next;
          acc  <= acc >> CHUNK_BITS;
          msk  <= msk >> CHUNK_BITS;
          live <= live >> CHUNK_BITS;
          idx  <= idx + CW'(1);
          if (last_chunk) begin
            bool_share <= out_ext[FIELD_W-1:0];
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an item was taken");

  a_done_after_use: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_USE))
    else $error("result strobe without a finished lookup");

  a_use_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_USE) |-> ($past(state) == S_READ))
    else $error("table data used without a read cycle");

  a_no_write_in_lookup: assert property (@(posedge clk) disable iff (rst)
    ((state == S_READ) || (state == S_USE)) |-> !ram_we)
    else $error("table written during the lookup walk");

endmodule

`default_nettype wire

[dv/bool_share_checker.sv]
`timescale 1ns / 100ps

module bool_share_checker #(
  parameter int CHUNKS     = 4,
  parameter int CHUNK_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  mat_pkg::field_t arith_share,
  input  mat_pkg::field_t mask_value,
  input  logic            carry_flip,
  input  mat_pkg::field_t chunk_random,
  input  logic            done,
  input  mat_pkg::field_t bool_share,
  output int              fail_count,
  output int              open_count,
  output int              checked_count
);

  import mat_pkg::*;

  localparam int TOTAL_BITS = CHUNKS * CHUNK_BITS;
  localparam int TAB_DEPTH = 2 * CHUNKS * (2 ** CHUNK_BITS);
  localparam int unsigned CHUNK_MAX = (2 ** CHUNK_BITS) - 1;
  localparam logic [63:0] WORD_MASK = (TOTAL_BITS >= 64) ? 64'hffff_ffff_ffff_ffff :
                                      ((64'd1 << TOTAL_BITS) - 64'd1);

  // own copy of the carry table, rebuilt for every item
  logic [CHUNK_BITS:0] carry_tab [TAB_DEPTH];

  field_t expected_shares [$];
  int     n_fail;
  int     n_checked;

  function automatic int unsigned tab_index(int unsigned chunk, int unsigned carry,
                                            int unsigned val);
    return ((chunk << (CHUNK_BITS + 1)) | ((carry & 1) << CHUNK_BITS) | (val & CHUNK_MAX))
           % TAB_DEPTH;
  endfunction

  function automatic field_t predict_bool_share(field_t share, field_t msk_in, logic rho,
                                                field_t rand_w);
    logic [63:0]         acc;
    logic [63:0]         msk;
    logic [63:0]         rnd;
    logic [63:0]         live;
    logic [63:0]         res;
    logic [CHUNK_BITS:0] ent;
    int unsigned         ri;
    int unsigned         key;
    int unsigned         ml;
    int unsigned         beta;
    rnd = 64'(rand_w) & WORD_MASK;
    for (int i = 0; i < CHUNKS; i++) begin
      ri  = int'(rnd >> (i * CHUNK_BITS)) & CHUNK_MAX;
      key = (32'(rho) << CHUNK_BITS) | ri;
      for (int unsigned v = 0; v <= CHUNK_MAX; v++) begin
        carry_tab[tab_index(i, 32'(rho), v)]  = (CHUNK_BITS+1)'((v + ri) ^ key);
        carry_tab[tab_index(i, 32'(!rho), v)] = (CHUNK_BITS+1)'((v + ri + 1) ^ key);
      end
    end
    acc  = (64'(share) - rnd) & WORD_MASK;
    msk  = 64'(msk_in);
    live = WORD_MASK;
    res  = '0;
    beta = 32'(rho);
    // walk the chunks low to high, carry travels masked through the table
    for (int i = 0; i < CHUNKS; i++) begin
      ml   = int'(msk) & CHUNK_MAX;
      acc  = (acc + 64'(ml)) & live;
      ent  = carry_tab[tab_index(i, beta, int'(acc) & CHUNK_MAX)];
      beta = 32'(ent[CHUNK_BITS]);
      res  = res | ((64'(ent[CHUNK_BITS-1:0]) ^ 64'(ml)) << (i * CHUNK_BITS));
      acc  = acc >> CHUNK_BITS;
      msk  = msk >> CHUNK_BITS;
      live = live >> CHUNK_BITS;
    end
    res = (res ^ rnd) & WORD_MASK;
    return res[31:0];
  endfunction

  initial begin
    n_fail    = 0;
    n_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_shares.push_back(predict_bool_share(arith_share, mask_value, carry_flip,
                                                     chunk_random));
      end
      if (done) begin
        if (expected_shares.size() == 0) begin
          $display("%0t: bool_share expected none, got %h", $time, bool_share);
          n_fail++;
        end else begin
          if (bool_share !== expected_shares[0]) begin
            $display("%0t: bool_share expected %h, got %h", $time, expected_shares[0],
                     bool_share);
            n_fail++;
          end
          void'(expected_shares.pop_front());
          n_checked++;
        end
      end
    end
    fail_count    <= n_fail;
    open_count    <= expected_shares.size();
    checked_count <= n_checked;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  import mat_pkg::*;

  localparam int CHUNKS     = 4;
  localparam int CHUNK_BITS = 8;
  localparam int N_DIRECTED = 14;
  localparam int N_PER_PHASE = 69;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  field_t arith_share;
  field_t mask_value;
  logic   carry_flip;
  field_t chunk_random;
  logic   done;
  field_t bool_share;
  int     fail_count;
  int     open_count;
  int     checked_count;
  int     n_sent;

  // sender idle percentage per phase
  int idle_pct [4] = '{0, 55, 0, 18};

  // edge values: zeros, ones, full carry chains, secret of zero
  field_t dir_a [N_DIRECTED] = '{32'h0, 32'h0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                 32'h1, 32'h0, 32'hffffffff, 32'h0, 32'h80000000,
                                 32'h00ff00ff, 32'h7fffffff, 32'h12345678, 32'h00000100};
  field_t dir_m [N_DIRECTED] = '{32'h0, 32'h0, 32'hffffffff, 32'hffffffff, 32'h1,
                                 32'hffffffff, 32'h0, 32'h0, 32'hffffffff, 32'h80000000,
                                 32'hff00ff00, 32'h1, 32'hedcba988, 32'hffffff00};
  logic   dir_f [N_DIRECTED] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                 1'b0, 1'b1, 1'b0, 1'b1};
  field_t dir_r [N_DIRECTED] = '{32'h0, 32'h0, 32'hffffffff, 32'hffffffff, 32'h0,
                                 32'h0, 32'hffffffff, 32'h0, 32'h12345678, 32'h80000000,
                                 32'h0f0f0f0f, 32'hffffffff, 32'ha5a5a5a5, 32'h01010101};

  masked_a2b_table_conversion #(
    .CHUNKS(CHUNKS),
    .CHUNK_BITS(CHUNK_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .arith_share(arith_share),
    .mask_value(mask_value),
    .carry_flip(carry_flip),
    .chunk_random(chunk_random),
    .done(done),
    .bool_share(bool_share)
  );

  bool_share_checker #(
    .CHUNKS(CHUNKS),
    .CHUNK_BITS(CHUNK_BITS)
  ) share_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .arith_share(arith_share),
    .mask_value(mask_value),
    .carry_flip(carry_flip),
    .chunk_random(chunk_random),
    .done(done),
    .bool_share(bool_share),
    .fail_count(fail_count),
    .open_count(open_count),
    .checked_count(checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  // start stays high from one item to the next unless a gap is wanted
  task automatic send_item(field_t a, field_t m, logic rho, field_t r);
    @(negedge clk);
    start        <= 1'b1;
    arith_share  <= a;
    mask_value   <= m;
    carry_flip   <= rho;
    chunk_random <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    start        <= 1'b0;
    arith_share  <= $urandom;
    mask_value   <= $urandom;
    carry_flip   <= 1'($urandom_range(0, 1));
    chunk_random <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (open_count != 0) @(negedge clk);
  endtask

  task automatic pick_item(output field_t a, output field_t m, output logic rho,
                           output field_t r);
    int kind;
    kind = $urandom_range(0, 9);
    a    = $urandom;
    m    = $urandom;
    rho  = 1'($urandom_range(0, 1));
    r    = $urandom;
    case (kind)
      7: begin
        // tiny secret, borrows run through every chunk
        a = 32'(32'h0 - m + $urandom_range(0, 3));
      end
      8: begin
        // secret near the top, carries run through every chunk
        a = 32'(32'hffffffff - m - $urandom_range(0, 3));
      end
      9: begin
        r = $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    field_t a;
    field_t m;
    logic   rho;
    field_t r;
    int     gap;
    rst          = 1'b1;
    start        = 1'b0;
    arith_share  = '0;
    mask_value   = '0;
    carry_flip   = 1'b0;
    chunk_random = '0;
    n_sent       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(dir_a[i], dir_m[i], dir_f[i], dir_r[i]);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < N_PER_PHASE; k++) begin
        if ($urandom_range(1, 100) <= idle_pct[ph]) begin
          // short gaps land mid-conversion, long ones straddle the done cycle
          gap = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(2045, 2075);
          hold_off(gap);
        end
        pick_item(a, m, rho, r);
        send_item(a, m, rho, r);
      end
      drain();
    end

    repeat (2100) @(negedge clk);
    $display("ran %0d items (%0d directed), %0d shares checked over four gap patterns",
             n_sent, N_DIRECTED, checked_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mat_pkg.sv
rtl/mat_table_ram.sv
rtl/mat_entry_gen.sv
rtl/masked_a2b_table_conversion.sv
dv/bool_share_checker.sv
dv/testbench.sv
